FILE: sv/lars_pkg.sv
// Shared types and constants for the life automaton row stepper.
package lars_pkg;

  localparam int unsigned ROW_W      = 64;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned WIDTH_W    = 7;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST   = 7'd64;
  localparam logic [COUNT_W-1:0] SURVIVE_MIN_RST = 4'd2;
  localparam logic [COUNT_W-1:0] SURVIVE_MAX_RST = 4'd3;
  localparam logic [COUNT_W-1:0] BIRTH_COUNT_RST = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH   = 4'd0,
    CFG_SURVIVE_MIN = 4'd1,
    CFG_SURVIVE_MAX = 4'd2,
    CFG_BIRTH_COUNT = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_ROW = 1'b0,
    KIND_EOF = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [COUNT_W-1:0] survive_min;
    logic [COUNT_W-1:0] survive_max;
    logic [COUNT_W-1:0] birth_count;
  } rule_t;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] cells;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_cells;
    logic             last_row;
  } out_item_t;

endpackage

FILE: sv/lars_lane.sv
// One cell lane: neighbor count and birth/survive rule.
module lars_lane
  import lars_pkg::*;
(
  input  logic [2:0] above,
  input  logic [2:0] mid,
  input  logic [2:0] below,
  input  logic       active,
  input  rule_t      rule,
  output logic       next_alive
);

  logic [COUNT_W-1:0] n;
  logic               alive;
  logic               keep;

  // Count the eight neighbors; the center of the middle row is the cell itself
  assign n = COUNT_W'(above[0]) + COUNT_W'(above[1]) + COUNT_W'(above[2])
           + COUNT_W'(mid[0]) + COUNT_W'(mid[2])
           + COUNT_W'(below[0]) + COUNT_W'(below[1]) + COUNT_W'(below[2]);

  assign alive = mid[1];

  // Apply the rule; columns past the row width stay dead
  always_comb begin
    if (alive) begin
      keep = (n >= rule.survive_min) && (n <= rule.survive_max);
    end else begin
      keep = (n == rule.birth_count);
    end
    next_alive = active & keep;
  end

endmodule

FILE: sv/lars_outbuf.sv
// Two-entry result queue between the lanes and the output channel.
module lars_outbuf
  import lars_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t   entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_item  = entry[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the result entry
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue over capacity");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full result queue");

  a_fill_second: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd1) |=> full)
    else $error("second entry not recorded");

endmodule

FILE: sv/life_automaton_row_step_top.sv
// Top level of the life automaton row stepper: row store, cell lanes, config.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid / in_ready   | in_item  (kind, cells)
//  out     | output    | out_valid / out_ready | out_item (next_cells, last_row)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One row request per cycle while the result queue is not full; a request
// taken with a row held queues a result; all MAX_WIDTH lanes are combinational.
// Reset clears held rows, loads default rules (B3/S23, width 64), empties queue.
// in_ready drops only while the two-entry result queue is full.
// cfg_ready is always high.
module life_automaton_row_step_top
  import lars_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIDTH_W-1:0]   row_width;
  rule_t                rule;
  logic [MAX_WIDTH-1:0] upper_row;
  logic [MAX_WIDTH-1:0] pending_row;
  logic                 pending_valid;

  logic                 in_accept;
  logic                 is_eof;
  logic                 full;
  logic                 push;
  out_item_t            push_item;
  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] below_row;
  logic [MAX_WIDTH+1:0] pad_above;
  logic [MAX_WIDTH+1:0] pad_mid;
  logic [MAX_WIDTH+1:0] pad_below;
  logic [MAX_WIDTH-1:0] lane_bits;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign in_accept = in_valid && in_ready;
  assign is_eof    = (item_kind_e'(in_item.kind) == KIND_EOF);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width        <= ROW_WIDTH_RST;
      rule.survive_min <= SURVIVE_MIN_RST;
      rule.survive_max <= SURVIVE_MAX_RST;
      rule.birth_count <= BIRTH_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        CFG_ROW_WIDTH:   row_width        <= cfg_data[WIDTH_W-1:0];
        CFG_SURVIVE_MIN: rule.survive_min <= cfg_data[COUNT_W-1:0];
        CFG_SURVIVE_MAX: rule.survive_max <= cfg_data[COUNT_W-1:0];
        CFG_BIRTH_COUNT: rule.birth_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Build the column mask and dead-bordered rows for the lanes
  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      mask[c] = (row_width > WIDTH_W'(c));
    end
    below_row = is_eof ? '0 : in_item.cells[MAX_WIDTH-1:0];
    pad_above = {1'b0, upper_row & mask, 1'b0};
    pad_mid   = {1'b0, pending_row & mask, 1'b0};
    pad_below = {1'b0, below_row & mask, 1'b0};
  end

  // One lane per column
  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_lane
    lars_lane u_lane (
      .above      (pad_above[c+2:c]),
      .mid        (pad_mid[c+2:c]),
      .below      (pad_below[c+2:c]),
      .active     (mask[c]),
      .rule       (rule),
      .next_alive (lane_bits[c])
    );
  end

  // Merge lane results into one result request
  assign push                 = in_accept && pending_valid;
  assign push_item.next_cells = ROW_W'(lane_bits);
  assign push_item.last_row   = is_eof;

  // Advance the row window
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row     <= '0;
      pending_row   <= '0;
      pending_valid <= 1'b0;
    end else if (in_accept) begin
      if (is_eof) begin
        upper_row     <= '0;
        pending_row   <= '0;
        pending_valid <= 1'b0;
      end else begin
        upper_row     <= pending_valid ? pending_row : '0;
        pending_row   <= in_item.cells[MAX_WIDTH-1:0];
        pending_valid <= 1'b1;
      end
    end
  end

  lars_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_eof) |=> (!pending_valid && upper_row == '0))
    else $error("end of frame left a row held");

  a_row_held: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !is_eof) |=> pending_valid)
    else $error("row not held after row request");

  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    (!pending_valid) |-> (!push && upper_row == '0))
    else $error("result or upper row without a held row");

endmodule

FILE: tb/life_automaton_row_step_top_tb.sv
// Self-checking testbench for the life automaton row stepper: random frames under many rule sets.
module life_automaton_row_step_top_tb;
  import lars_pkg::*;

  localparam int unsigned MAX_COLS      = 64;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned NUM_PHASES    = 9;
  localparam int unsigned CALM_PHASE    = 3;
  localparam int unsigned HOLD_PHASE    = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    rule_t              counts;
  } rule_setting_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus and expectations
  in_item_t  row_queue[$];
  out_item_t next_rows_due[$];
  logic      in_taken = 1'b0;
  logic      calm = 1'b0;
  logic      hold_wanted = 1'b0;
  logic      hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Shadow of the block: rules in force and the two held rows
  logic [WIDTH_W-1:0] live_width;
  rule_t              live_rule;
  logic [ROW_W-1:0]   above_row;
  logic [ROW_W-1:0]   held_row;
  logic               row_held;

  int unsigned fail_count = 0;
  int unsigned rows_taken = 0;
  int unsigned flushes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned watch_cycles = 0;

  life_automaton_row_step_top #(
    .MAX_WIDTH(MAX_COLS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Cell state with a dead border outside the row
  function automatic int unsigned cell_at(input logic [ROW_W-1:0] r, input int col);
    if (col < 0 || col >= ROW_W) return 0;
    return r[col];
  endfunction

  // Next state of the middle row under the rules and width in force
  function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] above,
                                                input logic [ROW_W-1:0] mid,
                                                input logic [ROW_W-1:0] below);
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] result;
    int unsigned      used;
    int unsigned      n;
    used = (live_width > MAX_COLS) ? MAX_COLS : live_width;
    mask = (used >= ROW_W) ? '1 : ((ROW_W'(1) << used) - ROW_W'(1));
    above &= mask;
    mid &= mask;
    below &= mask;
    result = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        n += cell_at(above, c + d) + cell_at(below, c + d);
        if (d != 0) n += cell_at(mid, c + d);
      end
      if (mid[c]) begin
        result[c] = (n >= live_rule.survive_min) && (n <= live_rule.survive_max);
      end else begin
        result[c] = (n == live_rule.birth_count);
      end
    end
    return result & mask;
  endfunction

  // Advance the shadow rows by one request and queue any result it owes
  function automatic void take_row(input in_item_t it);
    out_item_t due;
    if (it.kind == KIND_ROW) begin
      rows_taken++;
      if (row_held) begin
        due.next_cells = next_row(above_row, held_row, it.cells);
        due.last_row = 1'b0;
        next_rows_due.push_back(due);
        above_row = held_row;
      end else begin
        above_row = '0;
      end
      held_row = it.cells;
      row_held = 1'b1;
    end else begin
      flushes_taken++;
      if (row_held) begin
        due.next_cells = next_row(above_row, held_row, '0);
        due.last_row = 1'b1;
        next_rows_due.push_back(due);
      end
      above_row = '0;
      held_row = '0;
      row_held = 1'b0;
    end
  endfunction

  // Monitor: track config writes, predict on accepted requests, check results
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      in_taken <= 1'b0;
      live_width = ROW_WIDTH_RST;
      live_rule.survive_min = SURVIVE_MIN_RST;
      live_rule.survive_max = SURVIVE_MAX_RST;
      live_rule.birth_count = BIRTH_COUNT_RST;
      above_row = '0;
      held_row = '0;
      row_held = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_WIDTH:   live_width = cfg_data[WIDTH_W-1:0];
          CFG_SURVIVE_MIN: live_rule.survive_min = cfg_data[COUNT_W-1:0];
          CFG_SURVIVE_MAX: live_rule.survive_max = cfg_data[COUNT_W-1:0];
          CFG_BIRTH_COUNT: live_rule.birth_count = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) take_row(in_item);
      if (out_valid && out_ready) begin
        if (next_rows_due.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none actual next_cells=%h last_row=%b",
                   $time, out_item.next_cells, out_item.last_row);
        end else begin
          want = next_rows_due.pop_front();
          results_checked++;
          if (out_item.next_cells !== want.next_cells) begin
            fail_count++;
            $display("%0t: next_cells expected %h actual %h",
                     $time, want.next_cells, out_item.next_cells);
          end
          if (out_item.last_row !== want.last_row) begin
            fail_count++;
            $display("%0t: last_row expected %b actual %b",
                     $time, want.last_row, out_item.last_row);
          end
        end
      end
    end
  end

  // Driver: offer the next pending request, idling at random unless calm
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (row_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
        in_valid <= 1'b1;
        in_item <= row_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_wanted && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  // Watchdog
  initial begin
    while (watch_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      watch_cycles++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void queue_row(input item_kind_e k, input logic [ROW_W-1:0] c);
    in_item_t it;
    it.kind = k;
    it.cells = c;
    row_queue.push_back(it);
  endfunction

  // Mix of plain, sparse, dense and very sparse rows
  function automatic logic [ROW_W-1:0] random_cells();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a;
      1: return a & b;
      2: return a | b;
      default: return a & b & {$urandom, $urandom};
    endcase
  endfunction

  // Mostly whole frames; some stray flushes and frames that run into the next
  task automatic queue_random_frames(input int unsigned n_items);
    int unsigned queued;
    int unsigned rows;
    int unsigned pick;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_row(KIND_EOF, random_cells());
        queued++;
      end else begin
        rows = $urandom_range(1, 8);
        for (int r = 0; r < rows; r++) queue_row(KIND_ROW, random_cells());
        queued += rows;
        if (pick != 1) begin
          queue_row(KIND_EOF, random_cells());
          queued++;
        end
      end
    end
  endtask

  // Hold until every request is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (row_queue.size() != 0 || in_valid || next_rows_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all rule registers back to back, plus an unused index
  task automatic write_rules(input rule_setting_t s);
    cfg_reg_e              regs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    regs[0] = CFG_ROW_WIDTH;
    regs[1] = CFG_SURVIVE_MIN;
    regs[2] = CFG_SURVIVE_MAX;
    regs[3] = CFG_BIRTH_COUNT;
    vals[0] = s.width;
    vals[1] = {3'($urandom), s.counts.survive_min};
    vals[2] = {3'($urandom), s.counts.survive_max};
    vals[3] = {3'($urandom), s.counts.birth_count};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data <= CFG_DATA_W'($urandom);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Main sequence
  initial begin
    rule_setting_t s;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under the reset rules
    queue_row(KIND_EOF, '1);
    queue_row(KIND_ROW, '1);
    queue_row(KIND_EOF, '0);
    queue_row(KIND_ROW, '0);
    queue_row(KIND_ROW, ROW_W'(1) << 10);
    queue_row(KIND_ROW, ROW_W'(1) << 10);
    queue_row(KIND_ROW, ROW_W'(1) << 10);
    queue_row(KIND_ROW, '0);
    queue_row(KIND_EOF, '0);
    queue_row(KIND_ROW, {1'b1, 62'b0, 1'b1});
    queue_row(KIND_ROW, {2'b11, 60'b0, 2'b11});
    queue_row(KIND_ROW, {32{2'b10}});
    queue_row(KIND_ROW, {32{2'b01}});
    queue_row(KIND_ROW, '0);
    queue_row(KIND_EOF, {16{4'hD}});
    queue_row(KIND_ROW, '1);
    queue_row(KIND_ROW, '1);
    queue_row(KIND_ROW, '1);
    queue_row(KIND_EOF, '0);
    // Leave a row held across the first rule change
    queue_row(KIND_ROW, random_cells());
    queue_row(KIND_ROW, random_cells());
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: s = '{width: 7'd0,   counts: '{4'd2, 4'd3, 4'd3}};
        1: s = '{width: 7'd64,  counts: '{4'd2, 4'd3, 4'd3}};
        2: s = '{width: 7'd1,   counts: '{4'd0, 4'd8, 4'd0}};
        3: s = '{width: 7'd127, counts: '{4'd2, 4'd3, 4'd3}};
        4: s = '{width: 7'd63,  counts: '{4'd8, 4'd8, 4'd8}};
        5: s = '{width: 7'd3,   counts: '{4'd15, 4'd0, 4'd15}};
        6: begin
          s.width = WIDTH_W'($urandom_range(2, 64));
          s.counts.survive_min = COUNT_W'($urandom_range(0, 4));
          s.counts.survive_max = COUNT_W'($urandom_range(2, 8));
          s.counts.birth_count = COUNT_W'($urandom_range(1, 8));
        end
        7: begin
          s.width = WIDTH_W'($urandom);
          s.counts = rule_t'($urandom);
        end
        default: s = '{width: 7'd64, counts: '{4'd2, 4'd3, 4'd3}};
      endcase
      write_rules(s);
      calm = (p == CALM_PHASE);
      if (p == HOLD_PHASE) hold_wanted = 1'b1;
      queue_random_frames(PHASE_ITEMS);
      wait_drained();
    end

    if (next_rows_due.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, next_rows_due.size());
    end
    $display("Stepped %0d rows and %0d frame flushes under %0d rule sets;",
             rows_taken, flushes_taken, NUM_PHASES + 1);
    $display("%0d next-generation rows compared, %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/lars_pkg.sv
sv/lars_lane.sv
sv/lars_outbuf.sv
sv/life_automaton_row_step_top.sv
tb/life_automaton_row_step_top_tb.sv
